/* hw/rtl/vfe_pkg.sv */
package vfe_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int QUEUE_DEPTH     = 4;
    localparam int ADDR_W          = 5;

    localparam logic [30:0] SAT31        = 31'h7FFF_FFFF;
    localparam logic [30:0] MIN_MEAN_MAG = 31'd655;

    localparam logic [31:0] SCALE_RST = 32'h0100_0000;
    localparam logic [31:0] INV_RST   = 32'h0008_0000;
    localparam logic [30:0] THR_RST   = 31'd16384;

    typedef enum logic [2:0] {
        REG_SCALE = 3'd0,
        REG_INV   = 3'd1,
        REG_IEPE  = 3'd2,
        REG_GATE  = 3'd3,
        REG_THR   = 3'd4
    } t_reg;

    typedef struct packed {
        logic [31:0] inverse_count;
        logic        iepe_mode;
        logic        quiet_gate_enable;
        logic [30:0] quiet_threshold;
    } t_cfg;

    typedef struct packed {
        logic [31:0] mag;
        logic        neg;
        logic        last;
    } t_entry;

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    // Joins the two partial products of a 64 by 32 product shifted right by 16 or 32.
    function automatic logic [63:0] mul_combine(input logic [63:0] p_hi,
                                                input logic [63:0] p_lo,
                                                input logic        s32);
        logic [63:0] r;
        if (s32) begin
            r = sat_add64(p_hi, {32'd0, p_lo[63:32]});
        end else if (p_hi[63:48] != 16'd0) begin
            r = 64'hFFFF_FFFF_FFFF_FFFF;
        end else begin
            r = sat_add64({p_hi[47:0], 16'd0}, {16'd0, p_lo[63:16]});
        end
        return r;
    endfunction

    function automatic logic [30:0] sat31(input logic [63:0] v);
        return (v[63:31] != 33'd0) ? SAT31 : v[30:0];
    endfunction

endpackage

/* hw/rtl/vfe_mulshr.sv */
module vfe_mulshr (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [31:0] i_b,
    input  logic        i_s32,
    output logic        o_busy,
    output logic [63:0] o_res
);

    typedef enum logic [1:0] {M_IDLE, M_LO, M_HI, M_FIN} t_state;

    t_state      r_state;
    logic [63:0] r_a;
    logic [31:0] r_b;
    logic        r_s32;
    logic [63:0] r_plo;
    logic [63:0] r_phi;
    logic [63:0] r_res;
    logic [31:0] opa;
    logic [63:0] prod;

    assign opa   = (r_state == M_LO) ? r_a[31:0] : r_a[63:32];
    assign prod  = opa * r_b;
    assign o_busy = (r_state != M_IDLE);
    assign o_res  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_a;
                        r_b     <= i_b;
                        r_s32   <= i_s32;
                        r_state <= M_LO;
                    end
                end
                M_LO: begin
                    r_plo   <= prod;
                    r_state <= M_HI;
                end
                M_HI: begin
                    r_phi   <= prod;
                    r_state <= M_FIN;
                end
                M_FIN: begin
                    r_res   <= vfe_pkg::mul_combine(r_phi, r_plo, r_s32);
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/vfe_sqrt.sv */
module vfe_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic        o_busy,
    output logic [31:0] o_res
);

    typedef enum logic {Q_IDLE, Q_RUN} t_state;

    localparam int SQ_STEPS = 16;
    localparam int CW       = $clog2(SQ_STEPS);

    t_state        r_state;
    logic [63:0]   r_v;
    logic [63:0]   r_root;
    logic [63:0]   r_bit;
    logic [CW-1:0] r_cnt;
    logic [63:0]   v_n;
    logic [63:0]   root_n;
    logic [63:0]   bit_n;

    // Two digits of the bitwise square root per cycle.
    always_comb begin
        v_n    = r_v;
        root_n = r_root;
        bit_n  = r_bit;
        for (int k = 0; k < 2; k++) begin
            if (v_n >= root_n + bit_n) begin
                v_n    = v_n - (root_n + bit_n);
                root_n = (root_n >> 1) + bit_n;
            end else begin
                root_n = root_n >> 1;
            end
            bit_n = bit_n >> 2;
        end
    end

    assign o_busy = (r_state == Q_RUN);
    assign o_res  = r_root[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= Q_IDLE;
        end else begin
            case (r_state)
                Q_IDLE: begin
                    if (i_start) begin
                        r_v     <= i_val;
                        r_root  <= 64'd0;
                        r_bit   <= 64'h4000_0000_0000_0000;
                        r_cnt   <= CW'(SQ_STEPS - 1);
                        r_state <= Q_RUN;
                    end
                end
                Q_RUN: begin
                    r_v    <= v_n;
                    r_root <= root_n;
                    r_bit  <= bit_n;
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= Q_IDLE;
                    end
                end
                default: r_state <= Q_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/vfe_div.sv */
module vfe_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [30:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_busy,
    output logic [30:0] o_quo
);

    typedef enum logic {D_IDLE, D_RUN} t_state;

    localparam int DVD_W = 47;
    localparam int CW    = $clog2(DVD_W);

    t_state          r_state;
    logic [63:0]     r_den;
    logic [63:0]     r_rem;
    logic [DVD_W-1:0] r_dvd;
    logic [DVD_W-1:0] r_quo;
    logic [CW-1:0]   r_cnt;
    logic [64:0]     rem_sh;
    logic            fits;

    assign rem_sh = {r_rem, r_dvd[DVD_W-1]};
    assign fits   = (rem_sh >= {1'b0, r_den});
    assign o_busy = (r_state == D_RUN);
    assign o_quo  = (r_quo[DVD_W-1:31] != '0) ? vfe_pkg::SAT31 : r_quo[30:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_den <= i_den;
                        r_rem <= 64'd0;
                        r_dvd <= {i_num, 16'd0};
                        r_cnt <= CW'(DVD_W - 1);
                        if (i_den == 64'd0) begin
                            // A zero divisor reads as saturated at once.
                            r_quo <= '1;
                        end else begin
                            r_quo   <= '0;
                            r_state <= D_RUN;
                        end
                    end
                end
                D_RUN: begin
                    r_rem   <= fits ? 64'(rem_sh - {1'b0, r_den}) : rem_sh[63:0];
                    r_quo   <= {r_quo[DVD_W-2:0], fits};
                    r_dvd   <= r_dvd << 1;
                    r_cnt   <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/vfe_front.sv */
module vfe_front #(
    parameter int SAMPLE_BITS = vfe_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [SAMPLE_BITS-1:0] i_raw_sample,
    input  logic                          i_last_sample,
    input  logic [31:0]                   i_sample_scale,
    output logic                          o_q_push,
    input  logic                          i_q_full,
    output vfe_pkg::t_entry               o_entry
);

    localparam int SW = SAMPLE_BITS + 24;
    localparam logic [SW-1:0] NEG_LIM = SW'(64'h8000_0000);
    localparam logic [SW-1:0] POS_LIM = SW'(64'h7FFF_FFFF);

    logic                        r_valid;
    vfe_pkg::t_entry             r_entry;
    logic                        neg;
    logic [SAMPLE_BITS-1:0]      rmag;
    logic [SAMPLE_BITS+31:0]     prod;
    logic [SW-1:0]               scaled;
    logic [31:0]                 mag;
    logic                        accept;

    assign neg    = i_raw_sample[SAMPLE_BITS-1];
    assign rmag   = neg ? (~i_raw_sample + 1'b1) : i_raw_sample;
    assign prod   = rmag * i_sample_scale;
    assign scaled = prod[SAMPLE_BITS+31:8];

    always_comb begin
        if (neg) begin
            mag = (scaled > NEG_LIM) ? 32'h8000_0000 : scaled[31:0];
        end else begin
            mag = (scaled > POS_LIM) ? 32'h7FFF_FFFF : scaled[31:0];
        end
    end

    assign full     = r_valid && i_q_full;
    assign accept   = push && !full;
    assign o_q_push = r_valid && !i_q_full;
    assign o_entry  = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_valid      <= 1'b1;
                r_entry.mag  <= mag;
                r_entry.neg  <= neg;
                r_entry.last <= i_last_sample;
            end else if (o_q_push) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

/* hw/rtl/vfe_queue.sv */
module vfe_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  vfe_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output vfe_pkg::t_entry o_entry,
    output logic            o_empty
);

    localparam int DEPTH = vfe_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    vfe_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [PW:0]     r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* hw/rtl/vfe_back.sv */
module vfe_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vfe_pkg::t_cfg      i_cfg,
    input  logic               i_q_empty,
    input  vfe_pkg::t_entry    i_entry,
    output logic               o_q_pop,
    input  logic               pop,
    output logic               empty,
    output logic signed [31:0] o_mean_value,
    output logic [30:0]        o_rms_value,
    output logic [30:0]        o_peak_to_peak,
    output logic [30:0]        o_max_magnitude,
    output logic [30:0]        o_mean_magnitude,
    output logic [30:0]        o_fourth_moment,
    output logic [30:0]        o_waveform_index,
    output logic [30:0]        o_peak_index,
    output logic [30:0]        o_pulse_index,
    output logic [30:0]        o_skew_index,
    output logic [30:0]        o_kurtosis_index,
    output logic [30:0]        o_margin_index
);

    typedef enum logic [3:0] {
        S_IDLE, S_P2, S_P3, S_P4, S_ROOT, S_MGO, S_MWT, S_SQWT, S_GATE, S_DGO, S_DWT, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        MJ_MEAN, MJ_MS, MJ_MAG, MJ_FOURTH, MJ_CUBE, MJ_ROOT, MJ_M2, MJ_R2, MJ_R3, MJ_R4
    } t_job;

    typedef enum logic [2:0] {
        R_WAVE, R_PEAK, R_PULSE, R_SKEW, R_KURT, R_MARGIN
    } t_ratio;

    t_state             r_state;
    t_job               r_job;
    t_ratio             r_rsel;
    logic [31:0]        r_mag;
    logic               r_last;
    logic signed [31:0] r_max;
    logic signed [31:0] r_min;
    logic [63:0]        r_sum_lin;
    logic [63:0]        r_sq;
    logic [63:0]        r_cube;
    logic [63:0]        r_four;
    logic [63:0]        r_smag;
    logic [63:0]        r_sroot;
    logic [31:0]        r_mean;
    logic [30:0]        r_rms;
    logic               r_quiet;
    logic [30:0]        r_meanmag;
    logic [30:0]        r_fourth;
    logic [30:0]        r_cubem;
    logic [30:0]        r_m;
    logic [63:0]        r_m2;
    logic [63:0]        r_r2;
    logic [63:0]        r_r3;
    logic [63:0]        r_r4;
    logic [30:0]        r_ratio [6];
    logic               r_ovalid;
    logic [31:0]        r_o_mean;
    logic [30:0]        r_o_f [11];
    logic [30:0]        n_o_f [11];

    logic        m_start;
    logic [63:0] m_a;
    logic [31:0] m_b;
    logic        m_s32;
    logic        m_busy;
    logic [63:0] m_res;
    logic        sq_start;
    logic [63:0] sq_val;
    logic        sq_busy;
    logic [31:0] sq_res;
    logic        d_start;
    logic [30:0] d_num;
    logic [63:0] d_den;
    logic        d_busy;
    logic [30:0] d_quo;

    logic [31:0] y32;
    logic [64:0] lin_sum;
    logic [63:0] sabs;
    logic [31:0] minv;
    logic [32:0] p2p_full;
    logic [31:0] bigger;
    logic [30:0] p2p;
    logic [30:0] maxmag;
    logic [31:0] mean_neg_mag;

    vfe_mulshr u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (m_start),
        .i_a     (m_a),
        .i_b     (m_b),
        .i_s32   (m_s32),
        .o_busy  (m_busy),
        .o_res   (m_res)
    );

    vfe_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   (sq_val),
        .o_busy  (sq_busy),
        .o_res   (sq_res)
    );

    vfe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (d_start),
        .i_num   (d_num),
        .i_den   (d_den),
        .o_busy  (d_busy),
        .o_quo   (d_quo)
    );

    assign y32      = i_entry.neg ? (32'd0 - i_entry.mag) : i_entry.mag;
    assign lin_sum  = {r_sum_lin[63], r_sum_lin} + {{33{y32[31]}}, y32};
    assign sabs     = r_sum_lin[63] ? (64'd0 - r_sum_lin) : r_sum_lin;
    // The running maximum never drops below zero and the minimum never rises above it.
    assign minv     = 32'd0 - r_min;
    assign p2p_full = {1'b0, r_max} + {1'b0, minv};
    assign p2p      = (p2p_full[32:31] != 2'd0) ? vfe_pkg::SAT31 : p2p_full[30:0];
    assign bigger   = ($unsigned(r_max) > minv) ? r_max : minv;
    assign maxmag   = bigger[31] ? vfe_pkg::SAT31 : bigger[30:0];
    assign mean_neg_mag = (m_res > 64'h8000_0000) ? 32'h8000_0000 : m_res[31:0];

    always_comb begin
        n_o_f[0]  = r_rms;
        n_o_f[1]  = p2p;
        n_o_f[2]  = maxmag;
        n_o_f[3]  = r_meanmag;
        n_o_f[4]  = r_fourth;
        n_o_f[5]  = r_ratio[R_WAVE];
        n_o_f[6]  = r_ratio[R_PEAK];
        n_o_f[7]  = r_ratio[R_PULSE];
        n_o_f[8]  = r_ratio[R_SKEW];
        n_o_f[9]  = r_ratio[R_KURT];
        n_o_f[10] = r_ratio[R_MARGIN];
    end

    always_comb begin
        o_q_pop  = 1'b0;
        m_start  = 1'b0;
        m_a      = 64'd0;
        m_b      = 32'd0;
        m_s32    = 1'b0;
        sq_start = 1'b0;
        sq_val   = 64'd0;
        d_start  = 1'b0;
        d_num    = 31'd0;
        d_den    = 64'd0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop  = 1'b1;
                    m_start  = 1'b1;
                    m_a      = {32'd0, i_entry.mag};
                    m_b      = i_entry.mag;
                    sq_start = 1'b1;
                    sq_val   = {16'd0, i_entry.mag, 16'd0};
                end
            end
            S_P2, S_P3: begin
                if (!m_busy) begin
                    m_start = 1'b1;
                    m_a     = m_res;
                    m_b     = r_mag;
                end
            end
            S_MGO: begin
                m_start = 1'b1;
                m_b     = i_cfg.inverse_count;
                m_s32   = 1'b1;
                case (r_job)
                    MJ_MEAN:   m_a = sabs;
                    MJ_MS:     m_a = r_sq;
                    MJ_MAG:    m_a = r_smag;
                    MJ_FOURTH: m_a = r_four;
                    MJ_CUBE:   m_a = r_cube;
                    MJ_ROOT:   m_a = r_sroot;
                    MJ_M2: begin
                        m_a   = {33'd0, r_m};
                        m_b   = {1'b0, r_m};
                        m_s32 = 1'b0;
                    end
                    MJ_R2: begin
                        m_a   = {33'd0, r_rms};
                        m_b   = {1'b0, r_rms};
                        m_s32 = 1'b0;
                    end
                    MJ_R3: begin
                        m_a   = r_r2;
                        m_b   = {1'b0, r_rms};
                        m_s32 = 1'b0;
                    end
                    MJ_R4: begin
                        m_a   = r_r3;
                        m_b   = {1'b0, r_rms};
                        m_s32 = 1'b0;
                    end
                    default: m_a = 64'd0;
                endcase
            end
            S_MWT: begin
                if (!m_busy && r_job == MJ_MS && m_res[63:46] == 18'd0) begin
                    sq_start = 1'b1;
                    sq_val   = {m_res[47:0], 16'd0};
                end
            end
            S_DGO: begin
                d_start = 1'b1;
                case (r_rsel)
                    R_WAVE: begin
                        d_num = r_rms;
                        d_den = {33'd0, r_meanmag};
                    end
                    R_PEAK: begin
                        d_num = maxmag;
                        d_den = {33'd0, r_rms};
                    end
                    R_PULSE: begin
                        d_num = maxmag;
                        d_den = {33'd0, r_meanmag};
                    end
                    R_SKEW: begin
                        d_num = r_cubem;
                        d_den = r_r3;
                    end
                    R_KURT: begin
                        d_num = r_fourth;
                        d_den = r_r4;
                    end
                    R_MARGIN: begin
                        d_num = maxmag;
                        d_den = r_m2;
                    end
                    default: d_num = 31'd0;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_job     <= MJ_MEAN;
            r_rsel    <= R_WAVE;
            r_ovalid  <= 1'b0;
            r_max     <= '0;
            r_min     <= '0;
            r_sum_lin <= '0;
            r_sq      <= '0;
            r_cube    <= '0;
            r_four    <= '0;
            r_smag    <= '0;
            r_sroot   <= '0;
        end else begin
            if (pop && r_ovalid) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_mag  <= i_entry.mag;
                        r_last <= i_entry.last;
                        if ($signed(y32) > r_max) begin
                            r_max <= y32;
                        end
                        if ($signed(y32) < r_min) begin
                            r_min <= y32;
                        end
                        if (lin_sum[64] != lin_sum[63]) begin
                            r_sum_lin <= lin_sum[64] ? 64'h8000_0000_0000_0000
                                                     : 64'h7FFF_FFFF_FFFF_FFFF;
                        end else begin
                            r_sum_lin <= lin_sum[63:0];
                        end
                        r_smag  <= vfe_pkg::sat_add64(r_smag, {32'd0, i_entry.mag});
                        r_state <= S_P2;
                    end
                end
                S_P2: begin
                    if (!m_busy) begin
                        r_sq    <= vfe_pkg::sat_add64(r_sq, m_res);
                        r_state <= S_P3;
                    end
                end
                S_P3: begin
                    if (!m_busy) begin
                        r_cube  <= vfe_pkg::sat_add64(r_cube, m_res);
                        r_state <= S_P4;
                    end
                end
                S_P4: begin
                    if (!m_busy) begin
                        r_four  <= vfe_pkg::sat_add64(r_four, m_res);
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (!sq_busy) begin
                        r_sroot <= vfe_pkg::sat_add64(r_sroot, {32'd0, sq_res});
                        r_job   <= MJ_MEAN;
                        r_state <= r_last ? S_MGO : S_IDLE;
                    end
                end
                S_MGO: r_state <= S_MWT;
                S_MWT: begin
                    if (!m_busy) begin
                        case (r_job)
                            MJ_MEAN: begin
                                if (r_sum_lin[63]) begin
                                    r_mean <= 32'd0 - mean_neg_mag;
                                end else begin
                                    r_mean <= {1'b0, vfe_pkg::sat31(m_res)};
                                end
                                r_job   <= MJ_MS;
                                r_state <= i_cfg.iepe_mode ? S_MGO : S_OUT;
                            end
                            MJ_MS: begin
                                if (m_res[63:46] != 18'd0) begin
                                    r_rms   <= vfe_pkg::SAT31;
                                    r_state <= S_GATE;
                                end else begin
                                    r_state <= S_SQWT;
                                end
                            end
                            MJ_MAG: begin
                                r_meanmag <= (m_res == 64'd0) ? vfe_pkg::MIN_MEAN_MAG
                                                              : vfe_pkg::sat31(m_res);
                                r_job     <= MJ_FOURTH;
                                r_state   <= S_MGO;
                            end
                            MJ_FOURTH: begin
                                r_fourth <= vfe_pkg::sat31(m_res);
                                r_job    <= MJ_CUBE;
                                r_state  <= S_MGO;
                            end
                            MJ_CUBE: begin
                                r_cubem <= vfe_pkg::sat31(m_res);
                                r_job   <= MJ_ROOT;
                                r_state <= S_MGO;
                            end
                            MJ_ROOT: begin
                                r_m     <= vfe_pkg::sat31(m_res);
                                r_job   <= MJ_M2;
                                r_state <= S_MGO;
                            end
                            MJ_M2: begin
                                r_m2    <= m_res;
                                r_job   <= MJ_R2;
                                r_state <= S_MGO;
                            end
                            MJ_R2: begin
                                r_r2    <= m_res;
                                r_job   <= MJ_R3;
                                r_state <= S_MGO;
                            end
                            MJ_R3: begin
                                r_r3    <= m_res;
                                r_job   <= MJ_R4;
                                r_state <= S_MGO;
                            end
                            MJ_R4: begin
                                r_r4    <= m_res;
                                r_rsel  <= R_WAVE;
                                r_state <= S_DGO;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_SQWT: begin
                    if (!sq_busy) begin
                        r_rms   <= vfe_pkg::sat31({32'd0, sq_res});
                        r_state <= S_GATE;
                    end
                end
                S_GATE: begin
                    r_quiet <= i_cfg.quiet_gate_enable && (r_rms < i_cfg.quiet_threshold);
                    r_job   <= MJ_MAG;
                    if (i_cfg.quiet_gate_enable && (r_rms < i_cfg.quiet_threshold)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MGO;
                    end
                end
                S_DGO: r_state <= S_DWT;
                S_DWT: begin
                    if (!d_busy) begin
                        r_ratio[r_rsel] <= d_quo;
                        if (r_rsel == R_MARGIN) begin
                            r_state <= S_OUT;
                        end else begin
                            r_rsel  <= t_ratio'(r_rsel + 1'b1);
                            r_state <= S_DGO;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_o_mean <= r_mean;
                        // Rms survives the quiet gate; the other ten need it open, and all eleven need IEPE mode.
                        for (int k = 0; k < 11; k++) begin
                            if (!i_cfg.iepe_mode || (k != 0 && r_quiet)) begin
                                r_o_f[k] <= 31'd0;
                            end else begin
                                r_o_f[k] <= n_o_f[k];
                            end
                        end
                        r_max     <= '0;
                        r_min     <= '0;
                        r_sum_lin <= '0;
                        r_sq      <= '0;
                        r_cube    <= '0;
                        r_four    <= '0;
                        r_smag    <= '0;
                        r_sroot   <= '0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign empty            = !r_ovalid;
    assign o_mean_value     = r_o_mean;
    assign o_rms_value      = r_o_f[0];
    assign o_peak_to_peak   = r_o_f[1];
    assign o_max_magnitude  = r_o_f[2];
    assign o_mean_magnitude = r_o_f[3];
    assign o_fourth_moment  = r_o_f[4];
    assign o_waveform_index = r_o_f[5];
    assign o_peak_index     = r_o_f[6];
    assign o_pulse_index    = r_o_f[7];
    assign o_skew_index     = r_o_f[8];
    assign o_kurtosis_index = r_o_f[9];
    assign o_margin_index   = r_o_f[10];

    a_mul_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_start |-> !m_busy)
        else $error("multiplier started while busy");

    a_sqrt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_start |-> !sq_busy)
        else $error("square root started while busy");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_start |-> !d_busy)
        else $error("divider started while busy");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !r_ovalid) |=> (r_sq == 64'd0 && r_max == 32'sd0 && !empty))
        else $error("accumulators not cleared after a result");

endmodule

/* hw/rtl/vibration_feature_extractor.sv */
// Channel   Handshake                 Payload
// input     push / full               i_raw_sample, i_last_sample
// result    empty / pop               o_mean_value .. o_margin_index
// config    psel penable pwrite pready paddr, pwdata, prdata
//
// The square root unit (two digits a cycle over 64 bits) paces the back end per
// sample; the front end takes one sample a cycle, unless full, into a four-entry
// queue. A sample marked last adds finishing work, mostly six divisions in IEPE
// mode with the gate open. Reset is synchronous, active low, and clears the
// accumulators and loads the register defaults. A result still held when the next
// one is ready stalls the back end; intake then stops once the queue has filled.
module vibration_feature_extractor #(
    parameter int SAMPLE_BITS = vfe_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [SAMPLE_BITS-1:0] i_raw_sample,
    input  logic                          i_last_sample,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [31:0]            o_mean_value,
    output logic [30:0]                   o_rms_value,
    output logic [30:0]                   o_peak_to_peak,
    output logic [30:0]                   o_max_magnitude,
    output logic [30:0]                   o_mean_magnitude,
    output logic [30:0]                   o_fourth_moment,
    output logic [30:0]                   o_waveform_index,
    output logic [30:0]                   o_peak_index,
    output logic [30:0]                   o_pulse_index,
    output logic [30:0]                   o_skew_index,
    output logic [30:0]                   o_kurtosis_index,
    output logic [30:0]                   o_margin_index,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vfe_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [31:0] r_sample_scale;
    logic [31:0] r_inverse_count;
    logic        r_iepe_mode;
    logic        r_quiet_gate_enable;
    logic [30:0] r_quiet_threshold;

    vfe_pkg::t_cfg   cfg;
    vfe_pkg::t_entry f_entry;
    vfe_pkg::t_entry q_entry;
    logic            f_push;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_scale      <= vfe_pkg::SCALE_RST;
            r_inverse_count     <= vfe_pkg::INV_RST;
            r_iepe_mode         <= 1'b1;
            r_quiet_gate_enable <= 1'b0;
            r_quiet_threshold   <= vfe_pkg::THR_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[vfe_pkg::ADDR_W-1:2])
                vfe_pkg::REG_SCALE: r_sample_scale      <= pwdata;
                vfe_pkg::REG_INV:   r_inverse_count     <= pwdata;
                vfe_pkg::REG_IEPE:  r_iepe_mode         <= pwdata[0];
                vfe_pkg::REG_GATE:  r_quiet_gate_enable <= pwdata[0];
                vfe_pkg::REG_THR:   r_quiet_threshold   <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[vfe_pkg::ADDR_W-1:2])
            vfe_pkg::REG_SCALE: prdata = r_sample_scale;
            vfe_pkg::REG_INV:   prdata = r_inverse_count;
            vfe_pkg::REG_IEPE:  prdata = {31'd0, r_iepe_mode};
            vfe_pkg::REG_GATE:  prdata = {31'd0, r_quiet_gate_enable};
            vfe_pkg::REG_THR:   prdata = {1'b0, r_quiet_threshold};
            default:            prdata = 32'd0;
        endcase
    end

    assign cfg.inverse_count     = r_inverse_count;
    assign cfg.iepe_mode         = r_iepe_mode;
    assign cfg.quiet_gate_enable = r_quiet_gate_enable;
    assign cfg.quiet_threshold   = r_quiet_threshold;

    vfe_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_raw_sample   (i_raw_sample),
        .i_last_sample  (i_last_sample),
        .i_sample_scale (r_sample_scale),
        .o_q_push       (f_push),
        .i_q_full       (q_full),
        .o_entry        (f_entry)
    );

    vfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_entry (f_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_entry (q_entry),
        .o_empty (q_empty)
    );

    vfe_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_q_empty        (q_empty),
        .i_entry          (q_entry),
        .o_q_pop          (q_pop),
        .pop              (pop),
        .empty            (empty),
        .o_mean_value     (o_mean_value),
        .o_rms_value      (o_rms_value),
        .o_peak_to_peak   (o_peak_to_peak),
        .o_max_magnitude  (o_max_magnitude),
        .o_mean_magnitude (o_mean_magnitude),
        .o_fourth_moment  (o_fourth_moment),
        .o_waveform_index (o_waveform_index),
        .o_peak_index     (o_peak_index),
        .o_pulse_index    (o_pulse_index),
        .o_skew_index     (o_skew_index),
        .o_kurtosis_index (o_kurtosis_index),
        .o_margin_index   (o_margin_index)
    );

endmodule

/* bench/tb_vibration_feature_extractor.sv */
module tb_vibration_feature_extractor;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 500;
    localparam int RANDOM_ITEMS   = 950;
    localparam int N_FEAT         = 12;
    localparam int AW             = vfe_pkg::ADDR_W;

    typedef logic [N_FEAT-1:0][31:0] feat_t;

    typedef struct {
        logic [15:0] raw;
        logic        last;
        bit          typed;
        feat_t       feat;
    } row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic signed [15:0] i_raw_sample;
    logic        i_last_sample;
    logic        empty;
    logic        pop;
    logic signed [31:0] o_mean_value;
    logic [30:0] o_rms_value, o_peak_to_peak, o_max_magnitude, o_mean_magnitude;
    logic [30:0] o_fourth_moment, o_waveform_index, o_peak_index, o_pulse_index;
    logic [30:0] o_skew_index, o_kurtosis_index, o_margin_index;
    logic        psel, penable, pwrite;
    logic [AW-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;

    vibration_feature_extractor uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_raw_sample(i_raw_sample), .i_last_sample(i_last_sample),
        .empty(empty), .pop(pop),
        .o_mean_value(o_mean_value), .o_rms_value(o_rms_value),
        .o_peak_to_peak(o_peak_to_peak), .o_max_magnitude(o_max_magnitude),
        .o_mean_magnitude(o_mean_magnitude), .o_fourth_moment(o_fourth_moment),
        .o_waveform_index(o_waveform_index), .o_peak_index(o_peak_index),
        .o_pulse_index(o_pulse_index), .o_skew_index(o_skew_index),
        .o_kurtosis_index(o_kurtosis_index), .o_margin_index(o_margin_index),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    string feat_name [N_FEAT] = '{"mean_value", "rms_value", "peak_to_peak",
        "max_magnitude", "mean_magnitude", "fourth_moment", "waveform_index",
        "peak_index", "pulse_index", "skew_index", "kurtosis_index", "margin_index"};

    // Predictor copy of the configuration and the block accumulators.
    logic [31:0] cfg_scale, cfg_inv;
    logic        cfg_iepe, cfg_gate;
    logic [30:0] cfg_thr;
    logic signed [31:0] acc_max, acc_min;
    logic signed [63:0] acc_lin;
    logic [63:0] acc_sq, acc_cube, acc_four, acc_mag, acc_root;

    feat_t feature_q [$];
    int    errors;
    int    idle_cycles;
    bit    send_fast, take_fast;

    function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [31:0] b,
                                              input int s);
        logic [95:0] p;
        p = ({32'd0, a} * {64'd0, b}) >> s;
        return (p[95:64] != 32'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
    endfunction

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] r, t;
        r = 64'd0;
        for (int i = 31; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic logic [63:0] clamp31(input logic [63:0] v);
        return (v > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : v;
    endfunction

    function automatic logic [63:0] ratio_q16(input logic [63:0] num, input logic [63:0] den);
        if (den == 64'd0) return 64'h7FFF_FFFF;
        return clamp31({num[30:0], 16'd0} / den);
    endfunction

    task automatic clear_block();
        acc_max = 0; acc_min = 0; acc_lin = 0;
        acc_sq = 0; acc_cube = 0; acc_four = 0; acc_mag = 0; acc_root = 0;
    endtask

    task automatic predict_features(input logic [15:0] raw, input logic last,
                                    output bit emit, output feat_t r);
        logic        neg, gated;
        logic [63:0] rmag, a, p2, p3, p4, sabs, mm, ms, rms, maxv, minv, maxmag;
        logic [63:0] meanmag, fourth, cubem, r2, r3, r4, m, m2;
        logic signed [63:0] y;
        logic signed [64:0] t;
        neg  = raw[15];
        rmag = neg ? (64'h10000 - {48'd0, raw}) : {48'd0, raw};
        a    = (rmag * {32'd0, cfg_scale}) >> 8;
        if (neg) begin
            if (a > 64'h8000_0000) a = 64'h8000_0000;
            y = -$signed(a);
        end else begin
            a = clamp31(a);
            y = $signed(a);
        end
        if (y > 64'(acc_max)) acc_max = y[31:0];
        if (y < 64'(acc_min)) acc_min = y[31:0];
        t = 65'(acc_lin) + 65'(y);
        if (t > 65'sh0_7FFF_FFFF_FFFF_FFFF) acc_lin = 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (t < -65'sh0_8000_0000_0000_0000) acc_lin = 64'sh8000_0000_0000_0000;
        else acc_lin = t[63:0];
        p2 = mul_shift(a, a[31:0], 16);
        p3 = mul_shift(p2, a[31:0], 16);
        p4 = mul_shift(p3, a[31:0], 16);
        acc_sq   = add_sat(acc_sq, p2);
        acc_cube = add_sat(acc_cube, p3);
        acc_four = add_sat(acc_four, p4);
        acc_mag  = add_sat(acc_mag, a);
        acc_root = add_sat(acc_root, floor_sqrt(a << 16));
        emit = last;
        r = '0;
        if (!last) return;

        sabs = (acc_lin < 0) ? (64'd0 - acc_lin) : acc_lin;
        mm   = mul_shift(sabs, cfg_inv, 32);
        if (acc_lin < 0) begin
            if (mm > 64'h8000_0000) mm = 64'h8000_0000;
            r[0] = 32'd0 - mm[31:0];
        end else begin
            r[0] = 32'(clamp31(mm));
        end
        if (cfg_iepe) begin
            ms  = mul_shift(acc_sq, cfg_inv, 32);
            rms = (ms >= (64'd1 << 46)) ? 64'h7FFF_FFFF : clamp31(floor_sqrt(ms << 16));
            r[1] = 32'(rms);
            gated = cfg_gate && (rms < {33'd0, cfg_thr});
            if (!gated) begin
                maxv    = 64'(acc_max);
                minv    = 64'd0 - 64'(acc_min);
                maxmag  = clamp31(maxv > minv ? maxv : minv);
                meanmag = mul_shift(acc_mag, cfg_inv, 32);
                // An all-zero block would divide by zero, so the floor value stands in.
                if (meanmag == 0) meanmag = {33'd0, vfe_pkg::MIN_MEAN_MAG};
                meanmag = clamp31(meanmag);
                fourth  = clamp31(mul_shift(acc_four, cfg_inv, 32));
                cubem   = clamp31(mul_shift(acc_cube, cfg_inv, 32));
                r2 = mul_shift(rms, rms[31:0], 16);
                r3 = mul_shift(r2, rms[31:0], 16);
                r4 = mul_shift(r3, rms[31:0], 16);
                m  = clamp31(mul_shift(acc_root, cfg_inv, 32));
                m2 = mul_shift(m, m[31:0], 16);
                r[2]  = 32'(clamp31(maxv + minv));
                r[3]  = 32'(maxmag);
                r[4]  = 32'(meanmag);
                r[5]  = 32'(fourth);
                r[6]  = 32'(ratio_q16(rms, meanmag));
                r[7]  = 32'(ratio_q16(maxmag, rms));
                r[8]  = 32'(ratio_q16(maxmag, meanmag));
                r[9]  = 32'(ratio_q16(cubem, r3));
                r[10] = 32'(ratio_q16(fourth, r4));
                r[11] = 32'(ratio_q16(maxmag, m2));
            end
        end
        clear_block();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Result side: compare every accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        feat_t got, want;
        if (i_rst_n && pop && !empty) begin
            got = {1'b0, o_margin_index, 1'b0, o_kurtosis_index, 1'b0, o_skew_index,
                   1'b0, o_pulse_index, 1'b0, o_peak_index, 1'b0, o_waveform_index,
                   1'b0, o_fourth_moment, 1'b0, o_mean_magnitude, 1'b0, o_max_magnitude,
                   1'b0, o_peak_to_peak, 1'b0, o_rms_value, o_mean_value};
            if (feature_q.size() == 0) begin
                $error("feature result with no request outstanding");
                errors++;
            end else begin
                want = feature_q.pop_front();
                for (int i = 0; i < N_FEAT; i++) begin
                    if (got[i] !== want[i]) begin
                        $error("%s: expected %h, actual %h", feat_name[i], want[i], got[i]);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        int w;
        pop = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            w = take_fast ? 0 : $urandom_range(0, 8);
            if (w > 0) begin
                pop <= 1'b0;
                repeat (w) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            @(negedge i_clk);
        end
    end

    task automatic send_sample(input logic [15:0] raw, input logic last,
                               input bit typed, input feat_t typed_feat);
        int    w;
        bit    emit;
        feat_t f;
        w = send_fast ? 0 : $urandom_range(0, 8);
        if (w > 0) begin
            push <= 1'b0;
            repeat (w) @(negedge i_clk);
        end
        push          <= 1'b1;
        i_raw_sample  <= raw;
        i_last_sample <= last;
        do @(posedge i_clk); while (full);
        predict_features(raw, last, emit, f);
        if (emit) feature_q.push_back(typed ? typed_feat : f);
        @(negedge i_clk);
    endtask

    task automatic reg_access(input vfe_pkg::t_reg idx, input logic [31:0] wdata);
        logic [31:0] mask, rd;
        mask = (idx == vfe_pkg::REG_IEPE || idx == vfe_pkg::REG_GATE) ? 32'd1 :
               (idx == vfe_pkg::REG_THR) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
        for (int rw = 1; rw >= 0; rw--) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= rw[0];
            paddr   <= AW'(idx) << 2;
            pwdata  <= wdata;
            @(negedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            rd = prdata;
            @(negedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(negedge i_clk);
            if (rw == 0 && (rd & mask) !== (wdata & mask)) begin
                $error("register %0d readback: expected %h, actual %h",
                       idx, wdata & mask, rd & mask);
                errors++;
            end
        end
        case (idx)
            vfe_pkg::REG_SCALE: cfg_scale = wdata;
            vfe_pkg::REG_INV:   cfg_inv   = wdata;
            vfe_pkg::REG_IEPE:  cfg_iepe  = wdata[0];
            vfe_pkg::REG_GATE:  cfg_gate  = wdata[0];
            vfe_pkg::REG_THR:   cfg_thr   = wdata[30:0];
            default: ;
        endcase
    endtask

    // Lower push, wait for all outstanding results, then let the back end drain.
    task automatic drain_block();
        push <= 1'b0;
        while (feature_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [15:0] draw_sample();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        row_t  dir [$];
        row_t  rw;
        feat_t zero_feat;
        logic [31:0] ph_scale, ph_inv, ph_thr;
        logic  ph_iepe, ph_gate;
        int    sent, len, phase;

        errors = 0;
        idle_cycles = 0;
        send_fast = 1'b0;
        take_fast = 1'b0;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_raw_sample = '0;
        i_last_sample = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cfg_scale = vfe_pkg::SCALE_RST; cfg_inv = vfe_pkg::INV_RST;
        cfg_iepe = 1'b1; cfg_gate = 1'b0; cfg_thr = vfe_pkg::THR_RST;
        clear_block();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // A lone zero sample: the mean magnitude floor applies and the ratios over
        // rms, its powers and the squared mean root hit the zero-divisor saturation.
        zero_feat = '0;
        zero_feat[4]  = {1'b0, vfe_pkg::MIN_MEAN_MAG};
        zero_feat[7]  = {1'b0, vfe_pkg::SAT31};
        zero_feat[9]  = {1'b0, vfe_pkg::SAT31};
        zero_feat[10] = {1'b0, vfe_pkg::SAT31};
        zero_feat[11] = {1'b0, vfe_pkg::SAT31};
        dir.push_back('{16'h0000, 1'b1, 1'b1, zero_feat});
        dir.push_back('{16'h7FFF, 1'b1, 1'b0, '0});
        dir.push_back('{16'h8000, 1'b1, 1'b0, '0});
        dir.push_back('{16'h0001, 1'b0, 1'b0, '0});
        dir.push_back('{16'hFFFF, 1'b1, 1'b0, '0});
        dir.push_back('{16'h7FFF, 1'b0, 1'b0, '0});
        dir.push_back('{16'h8000, 1'b1, 1'b0, '0});
        for (int i = 0; i < 6; i++) dir.push_back('{16'h0000, 1'b0, 1'b0, '0});
        dir.push_back('{16'h0000, 1'b1, 1'b0, '0});
        for (int i = 0; i < 4; i++) dir.push_back('{16'h1234 << i, 1'b0, 1'b0, '0});
        dir.push_back('{16'hEDCC, 1'b1, 1'b0, '0});
        foreach (dir[i]) begin
            rw = dir[i];
            send_sample(rw.raw, rw.last, rw.typed, rw.feat);
        end
        drain_block();

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case (phase)
                0: begin ph_scale = 32'hFFFF_FFFF; ph_inv = 32'hFFFF_FFFF;
                         ph_iepe = 1; ph_gate = 0; ph_thr = 0; end
                1: begin ph_scale = 0; ph_inv = 0;
                         ph_iepe = 0; ph_gate = 1; ph_thr = 32'h7FFF_FFFF; end
                2: begin ph_scale = 32'h0100_0000; ph_inv = 32'h1000_0000;
                         ph_iepe = 1; ph_gate = 1; ph_thr = 32'h0001_0000; end
                3: begin ph_scale = 32'h0010_0000; ph_inv = 32'h2000_0000;
                         ph_iepe = 1; ph_gate = 1; ph_thr = 0; end
                default: begin
                    ph_scale = $urandom;
                    ph_inv   = ($urandom_range(0, 1) != 0) ? $urandom
                                                           : 32'hFFFF_FFFF / $urandom_range(1, 16);
                    ph_iepe  = ($urandom_range(0, 3) != 0);
                    ph_gate  = $urandom_range(0, 1);
                    ph_thr   = $urandom >> $urandom_range(1, 20);
                end
            endcase
            reg_access(vfe_pkg::REG_SCALE, ph_scale);
            reg_access(vfe_pkg::REG_INV, ph_inv);
            reg_access(vfe_pkg::REG_IEPE, {31'd0, ph_iepe});
            reg_access(vfe_pkg::REG_GATE, {31'd0, ph_gate});
            reg_access(vfe_pkg::REG_THR, ph_thr);
            send_fast = ($urandom_range(0, 3) == 0);
            take_fast = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 100 && sent < RANDOM_ITEMS; n += len) begin
                // Mostly short blocks; now and then a long one.
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 16);
                for (int k = 0; k < len; k++) begin
                    send_sample(draw_sample(), k == len - 1, 1'b0, '0);
                    sent++;
                end
            end
            drain_block();
            phase++;
        end

        if (errors == 0 && feature_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            if (feature_q.size() != 0) $error("%0d feature results never arrived",
                                              feature_q.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/vfe_pkg.sv
hw/rtl/vfe_mulshr.sv
hw/rtl/vfe_sqrt.sv
hw/rtl/vfe_div.sv
hw/rtl/vfe_front.sv
hw/rtl/vfe_queue.sv
hw/rtl/vfe_back.sv
hw/rtl/vibration_feature_extractor.sv
bench/tb_vibration_feature_extractor.sv
